### rtl/cfdp_pkg.sv
// shared types, constants and calendar helpers for the date pair search block
`timescale 1ns / 1ps

package cfdp_pkg;

    // field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DATE_W   = DAY_W + MONTH_W + YEAR_W;
    localparam int SERIAL_W = 22;
    localparam int SUM_W    = 24;
    localparam int INDEX_W  = 7;
    localparam int ROLE_W   = 2;

    // serial saturation limit
    localparam logic [SERIAL_W-1:0] SERIAL_MAX = 22'd4194303;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for 14-bit x
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 27;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam int DAYS_PER_YEAR = 365;
    localparam int CUM_W         = 9;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // result roles
    localparam logic [ROLE_W-1:0] ROLE_CLOSE_A = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_CLOSE_B = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_FAR_A   = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_FAR_B   = 2'd3;

    // one classified date on its way from front to back
    typedef struct packed {
        logic                last;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [SERIAL_W-1:0] serial;
    } date_item_t;

    // one result on its way to the output port
    typedef struct packed {
        logic                too_few;
        logic [ROLE_W-1:0]   role;
        logic [INDEX_W-1:0]  index;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [SERIAL_W-1:0] gap;
        logic                dropped;
        logic                last;
    } result_t;

    // days in the months before month mm of a common year; mm of 0 or above 12 gives 0
    function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] mm);
        logic [CUM_W-1:0] r;
        begin
            case (mm)
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/cfdp_front.sv
// front end: accepts dates and turns each one into a serial day number
`timescale 1ns / 1ps

module cfdp_front
    import cfdp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DAY_W-1:0]    in_day,
    input  logic [MONTH_W-1:0]  in_month,
    input  logic [YEAR_W-1:0]   in_year,
    input  logic                in_last,
    output logic                q_push,
    input  logic                q_ready,
    output date_item_t          q_item
);

    // stage a: products and clamped month
    logic                a_valid_reg;
    logic [SUM_W-2:0]    a_yb365_reg;
    logic [YEAR_W-3:0]   a_yb_q4_reg;
    logic [QUOT_W-1:0]   a_yb_q100_reg;
    logic [QUOT_W-1:0]   a_y_q100_reg;
    logic [MONTH_W-1:0]  a_mm_reg;
    logic [CUM_W-1:0]    a_cum_reg;
    logic [DAY_W-1:0]    a_day_reg;
    logic [MONTH_W-1:0]  a_month_reg;
    logic [YEAR_W-1:0]   a_year_reg;
    logic                a_last_reg;

    // stage b: finished item
    logic                b_valid_reg;
    date_item_t          b_item_reg;

    logic                pipe_en;
    logic [YEAR_W-1:0]   yb;
    logic [PROD_W-1:0]   yb_prod;
    logic [PROD_W-1:0]   y_prod;
    logic [MONTH_W-1:0]  mm;
    logic [YEAR_W-1:0]   y_cent;
    logic                div4;
    logic                div100;
    logic                leap;
    logic                leap_add;
    logic [SUM_W-1:0]    sum;
    logic [SERIAL_W-1:0] serial;

    // whole pipe moves unless a finished item is blocked by the queue
    assign pipe_en  = !b_valid_reg || q_ready;
    assign in_ready = pipe_en;
    assign q_push   = b_valid_reg && q_ready;
    assign q_item   = b_item_reg;

    // year count before this date and quotients by 100
    always_comb begin
        yb      = (in_year != '0) ? in_year - YEAR_W'(1) : '0;
        yb_prod = PROD_W'(yb) * PROD_W'(RECIP_100);
        y_prod  = PROD_W'(in_year) * PROD_W'(RECIP_100);
        mm      = (in_month > MONTH_W'(12)) ? MONTH_W'(12) : in_month;
    end

    // leap rule and serial sum
    always_comb begin
        y_cent   = YEAR_W'(a_y_q100_reg) * YEAR_W'(100);
        div4     = (a_year_reg[1:0] == 2'b00);
        div100   = (a_year_reg == y_cent);
        leap     = (div4 && !div100) || (div100 && (a_y_q100_reg[1:0] == 2'b00));
        leap_add = leap && (a_mm_reg > MONTH_W'(2));
        sum      = SUM_W'(a_yb365_reg) + SUM_W'(a_yb_q4_reg) - SUM_W'(a_yb_q100_reg)
                 + SUM_W'(a_yb_q100_reg[QUOT_W-1:2]) + SUM_W'(a_cum_reg)
                 + SUM_W'(leap_add) + SUM_W'(a_day_reg);
        serial   = (sum > SUM_W'(SERIAL_MAX)) ? SERIAL_MAX : sum[SERIAL_W-1:0];
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
        if (pipe_en) begin
            a_yb365_reg   <= (SUM_W-1)'(yb) * (SUM_W-1)'(DAYS_PER_YEAR);
            a_yb_q4_reg   <= yb[YEAR_W-1:2];
            a_yb_q100_reg <= yb_prod[PROD_W-1:RECIP_SHIFT];
            a_y_q100_reg  <= y_prod[PROD_W-1:RECIP_SHIFT];
            a_mm_reg      <= mm;
            a_cum_reg     <= cum_days(mm);
            a_day_reg     <= in_day;
            a_month_reg   <= in_month;
            a_year_reg    <= in_year;
            a_last_reg    <= in_last;
            b_item_reg.last   <= a_last_reg;
            b_item_reg.year   <= a_year_reg;
            b_item_reg.month  <= a_month_reg;
            b_item_reg.day    <= a_day_reg;
            b_item_reg.serial <= serial;
        end
    end

endmodule

### rtl/cfdp_queue.sv
// short queue of classified dates between front and back
`timescale 1ns / 1ps

module cfdp_queue
    import cfdp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    output logic       push_ready,
    input  date_item_t push_item,
    output logic       pop_valid,
    input  logic       pop,
    output date_item_t pop_item
);

    date_item_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W:0]      fill_reg;

    assign push_ready = (fill_reg != (QPTR_W+1)'(QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    property p_no_overrun;
        @(posedge aclk) disable iff (!aresetn)
        (fill_reg == (QPTR_W+1)'(QDEPTH)) |-> !push;
    endproperty
    a_no_overrun: assert property (p_no_overrun) else $error("queue overrun");

    property p_no_underrun;
        @(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> !pop;
    endproperty
    a_no_underrun: assert property (p_no_underrun) else $error("queue underrun");

    property p_fill_bound;
        @(posedge aclk) disable iff (!aresetn)
        fill_reg <= (QPTR_W+1)'(QDEPTH);
    endproperty
    a_fill_bound: assert property (p_fill_bound) else $error("queue fill out of range");

endmodule

### rtl/cfdp_back.sv
// back end: stores dates, scans all pairs and emits the closest and farthest pairs, or one too-few result
`timescale 1ns / 1ps

module cfdp_back
    import cfdp_pkg::*;
#(
    parameter int MAX_DATES = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_pop,
    input  date_item_t q_item,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    localparam int AW = (MAX_DATES > 1) ? $clog2(MAX_DATES) : 1;
    localparam int CW = $clog2(MAX_DATES + 1);
    localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ROW,
        S_ROW_LAT,
        S_PAIR,
        S_ORD,
        S_OLD,
        S_OWT
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [CW-1:0]       n_reg;
    logic [CW-1:0]       n_load;
    logic [AW-1:0]       i_reg;
    logic [AW-1:0]       jd_reg;
    logic                first_reg;
    logic [SERIAL_W-1:0] a_reg;
    logic [SERIAL_W-1:0] cg_reg;
    logic [SERIAL_W-1:0] fg_reg;
    logic [AW-1:0]       c1_reg;
    logic [AW-1:0]       c2_reg;
    logic [AW-1:0]       f1_reg;
    logic [AW-1:0]       f2_reg;
    logic [ROLE_W-1:0]   role_reg;
    logic                res_valid_reg;
    result_t             res_reg;

    // stores
    logic [SERIAL_W-1:0] serial_mem [MAX_DATES];
    logic [DATE_W-1:0]   date_mem [MAX_DATES];
    logic [SERIAL_W-1:0] ser_q;
    logic [DATE_W-1:0]   date_q;
    logic                wr_en;
    logic [AW-1:0]       ser_addr;
    logic                ser_rd_en;
    logic [AW-1:0]       date_addr;
    logic                date_rd_en;

    logic                stored;
    logic [SERIAL_W-1:0] gap;
    logic [IW-1:0]       idx_ext;

    assign q_pop     = q_valid && (state_reg == S_LOAD);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // capacity check and load bookkeeping
    always_comb begin
        stored     = (count_reg < CW'(MAX_DATES));
        wr_en      = q_pop && stored;
        count_next = stored ? count_reg + CW'(1) : count_reg;
        ovf_next   = ovf_reg || !stored;
        n_load     = count_next;
    end

    // read address selection
    always_comb begin
        ser_rd_en = 1'b0;
        ser_addr  = i_reg;
        case (state_reg)
            S_ROW: begin
                ser_rd_en = 1'b1;
                ser_addr  = i_reg;
            end
            S_ROW_LAT: begin
                ser_rd_en = 1'b1;
                ser_addr  = i_reg + AW'(1);
            end
            S_PAIR: begin
                ser_rd_en = 1'b1;
                ser_addr  = jd_reg + AW'(1);
            end
            default: begin
                ser_rd_en = 1'b0;
            end
        endcase
        date_rd_en = (state_reg == S_ORD);
        case (role_reg)
            ROLE_CLOSE_A: date_addr = c1_reg;
            ROLE_CLOSE_B: date_addr = c2_reg;
            ROLE_FAR_A:   date_addr = f1_reg;
            default:      date_addr = f2_reg;
        endcase
    end

    // serial store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            serial_mem[count_reg[AW-1:0]] <= q_item.serial;
        end
        if (ser_rd_en) begin
            ser_q <= serial_mem[ser_addr];
        end
    end

    // date store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            date_mem[count_reg[AW-1:0]] <= {q_item.year, q_item.month, q_item.day};
        end
        if (date_rd_en) begin
            date_q <= date_mem[date_addr];
        end
    end

    // gap of the current pair and index of the reported date
    always_comb begin
        gap     = (a_reg > ser_q) ? a_reg - ser_q : ser_q - a_reg;
        idx_ext = IW'(date_addr);
    end

    // load, scan and output sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            role_reg      <= ROLE_CLOSE_A;
            first_reg     <= 1'b0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (q_pop) begin
                        count_reg <= count_next;
                        ovf_reg   <= ovf_next;
                        if (q_item.last) begin
                            if (n_load < CW'(2)) begin
                                res_reg.too_few <= 1'b1;
                                res_reg.role    <= '0;
                                res_reg.index   <= '0;
                                res_reg.day     <= '0;
                                res_reg.month   <= '0;
                                res_reg.year    <= '0;
                                res_reg.gap     <= '0;
                                res_reg.dropped <= ovf_next;
                                res_reg.last    <= 1'b1;
                                res_valid_reg   <= 1'b1;
                                state_reg       <= S_OWT;
                            end else begin
                                n_reg     <= n_load;
                                i_reg     <= '0;
                                first_reg <= 1'b1;
                                state_reg <= S_ROW;
                            end
                        end
                    end
                end
                S_ROW: begin
                    state_reg <= S_ROW_LAT;
                end
                S_ROW_LAT: begin
                    a_reg     <= ser_q;
                    jd_reg    <= i_reg + AW'(1);
                    state_reg <= S_PAIR;
                end
                S_PAIR: begin
                    first_reg <= 1'b0;
                    if (first_reg || (gap < cg_reg)) begin
                        cg_reg <= gap;
                        c1_reg <= i_reg;
                        c2_reg <= jd_reg;
                    end
                    if (first_reg || (gap > fg_reg)) begin
                        fg_reg <= gap;
                        f1_reg <= i_reg;
                        f2_reg <= jd_reg;
                    end
                    if (CW'(jd_reg) == n_reg - CW'(1)) begin
                        if (CW'(i_reg) + CW'(2) == n_reg) begin
                            role_reg  <= ROLE_CLOSE_A;
                            state_reg <= S_ORD;
                        end else begin
                            i_reg     <= i_reg + AW'(1);
                            state_reg <= S_ROW;
                        end
                    end else begin
                        jd_reg <= jd_reg + AW'(1);
                    end
                end
                S_ORD: begin
                    res_reg.index <= idx_ext[INDEX_W-1:0];
                    state_reg     <= S_OLD;
                end
                S_OLD: begin
                    res_reg.too_few <= 1'b0;
                    res_reg.role    <= role_reg;
                    res_reg.year    <= date_q[DATE_W-1:DAY_W+MONTH_W];
                    res_reg.month   <= date_q[DAY_W+MONTH_W-1:DAY_W];
                    res_reg.day     <= date_q[DAY_W-1:0];
                    res_reg.gap     <= (role_reg == ROLE_CLOSE_A || role_reg == ROLE_CLOSE_B)
                                       ? cg_reg : fg_reg;
                    res_reg.dropped <= ovf_reg;
                    res_reg.last    <= (role_reg == ROLE_FAR_B);
                    res_valid_reg   <= 1'b1;
                    state_reg       <= S_OWT;
                end
                S_OWT: begin
                    if (res_ready) begin
                        res_valid_reg <= 1'b0;
                        if (res_reg.last) begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end else begin
                            role_reg  <= role_reg + ROLE_W'(1);
                            state_reg <= S_ORD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_DATES);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("date count beyond capacity");

    property p_pair_order;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PAIR) |-> (jd_reg > i_reg) && (CW'(jd_reg) < n_reg);
    endproperty
    a_pair_order: assert property (p_pair_order) else $error("scan pair out of order");

    property p_valid_in_wait;
        @(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> (state_reg == S_OWT);
    endproperty
    a_valid_in_wait: assert property (p_valid_in_wait) else $error("result shown outside wait");

    property p_too_few_last;
        @(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.too_few) |-> res_reg.last;
    endproperty
    a_too_few_last: assert property (p_too_few_last) else $error("too_few result not last");

endmodule

### rtl/closest_farthest_date_pair.sv
// A date passes front stages a and b and the queue; the back end stores it while loading.
// The pair scan starts on the last date of a set; S_ROW and S_ROW_LAT fetch each row's first
// date, then S_PAIR takes one pair per cycle through the serial store read port within the row.
// Results pass S_ORD, S_OLD and S_OWT (held on a stall); a set below two dates gives one result.
// Reset (aresetn low, synchronous) empties the pipe, the queue and the set count;
// the date stores are not cleared and no clearing pass runs after reset.
`timescale 1ns / 1ps

module closest_farthest_date_pair
    import cfdp_pkg::*;
#(
    parameter int MAX_DATES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // day [4:0], month [8:5], year [22:9], zero [23]
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // index [6:0], out_day [11:7], out_month [15:12], out_year [29:16],
    // gap_days [51:30], dropped [52], zero [55:53]
    output logic [55:0] m_axis_tdata,
    // role [1:0], too_few [2]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic       q_push;
    logic       q_push_ready;
    date_item_t q_push_item;
    logic       q_pop_valid;
    logic       q_pop;
    date_item_t q_pop_item;
    result_t    res;

    // serial computation
    cfdp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_day   (s_axis_tdata[4:0]),
        .in_month (s_axis_tdata[8:5]),
        .in_year  (s_axis_tdata[22:9]),
        .in_last  (s_axis_tlast),
        .q_push   (q_push),
        .q_ready  (q_push_ready),
        .q_item   (q_push_item)
    );

    // decoupling queue
    cfdp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_item   (q_pop_item)
    );

    // store, pair scan and result sequencing
    cfdp_back #(
        .MAX_DATES (MAX_DATES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_pop_valid),
        .q_pop     (q_pop),
        .q_item    (q_pop_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // result packing
    assign m_axis_tdata = {3'b000, res.dropped, res.gap, res.year, res.month, res.day, res.index};
    assign m_axis_tuser = {res.too_few, res.role};
    assign m_axis_tlast = res.last;

endmodule

### tb/cfdp_pair_checker.sv
// checker for the date pair search block: predicts every result from the input stream
`timescale 1ns / 1ps

module cfdp_pair_checker
    import cfdp_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,
    input  logic              s_axis_tlast,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [55:0]       m_axis_tdata,
    input  logic [2:0]        m_axis_tuser,
    input  logic              m_axis_tlast,
    output int unsigned       fail_count,
    output int unsigned       pending
);

    // one reported date as it leaves the block
    typedef struct packed {
        logic [2:0]          pad;
        logic                dropped;
        logic [SERIAL_W-1:0] gap;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [INDEX_W-1:0]  index;
        logic                too_few;
        logic [ROLE_W-1:0]   role;
        logic                last;
    } pair_report_t;

    // own copy of the loaded set
    int unsigned        day_numbers [DEPTH];
    logic [DATE_W-1:0]  loaded_dates [DEPTH];
    int unsigned        loaded_count;
    logic               set_overflowed;
    pair_report_t       reports_due [$];
    int unsigned        fault_total;

    // days before month m of a common year
    function automatic int unsigned days_before_month(input int unsigned m);
        case (m)
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 0;
        endcase
    endfunction

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // serial day number, 0001-01-01 is day 1, saturating at the field limit
    function automatic int unsigned serial_of_date(input logic [DAY_W-1:0] d,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0] y);
        int unsigned prior;
        int unsigned total;
        int unsigned mon;
        prior = (y > 0) ? y - 1 : 0;
        total = prior * 365 + prior / 4 - prior / 100 + prior / 400;
        mon   = (m > 12) ? 12 : m;
        total += days_before_month(mon);
        if (mon > 2 && leap_year(32'(y)))
            total += 1;
        total += d;
        return (total > SERIAL_MAX) ? SERIAL_MAX : total;
    endfunction

    function automatic int unsigned gap_between(input int unsigned i, input int unsigned j);
        return (day_numbers[i] > day_numbers[j]) ? day_numbers[i] - day_numbers[j]
                                                 : day_numbers[j] - day_numbers[i];
    endfunction

    function automatic pair_report_t date_report(input logic [ROLE_W-1:0] role,
                                                 input int unsigned idx,
                                                 input int unsigned gap,
                                                 input logic fin);
        pair_report_t r;
        r          = '0;
        r.role     = role;
        r.index    = idx[INDEX_W-1:0];
        r.day      = loaded_dates[idx][DAY_W-1:0];
        r.month    = loaded_dates[idx][DAY_W+MONTH_W-1:DAY_W];
        r.year     = loaded_dates[idx][DATE_W-1:DAY_W+MONTH_W];
        r.gap      = gap[SERIAL_W-1:0];
        r.dropped  = set_overflowed;
        r.last     = fin;
        return r;
    endfunction

    function automatic string describe(input pair_report_t r);
        return $sformatf("role=%0d idx=%0d date=%0d-%0d-%0d gap=%0d few=%0b drop=%0b last=%0b pad=%0d",
                         r.role, r.index, r.year, r.month, r.day, r.gap, r.too_few,
                         r.dropped, r.last, r.pad);
    endfunction

    // store one date; on the last date of a set search all pairs and queue the reports
    task automatic load_and_search(input logic [23:0] data, input logic fin);
        int unsigned  close_gap;
        int unsigned  far_gap;
        int unsigned  g;
        int unsigned  c1;
        int unsigned  c2;
        int unsigned  f1;
        int unsigned  f2;
        pair_report_t r;
        if (loaded_count < DEPTH) begin
            day_numbers[loaded_count]  = serial_of_date(data[DAY_W-1:0],
                                                        data[DAY_W+MONTH_W-1:DAY_W],
                                                        data[DATE_W-1:DAY_W+MONTH_W]);
            loaded_dates[loaded_count] = data[DATE_W-1:0];
            loaded_count++;
        end else begin
            set_overflowed = 1'b1;
        end
        if (fin) begin
            if (loaded_count < 2) begin
                r         = '0;
                r.too_few = 1'b1;
                r.dropped = set_overflowed;
                r.last    = 1'b1;
                reports_due.push_back(r);
            end else begin
                c1 = 0;
                c2 = 1;
                f1 = 0;
                f2 = 1;
                close_gap = gap_between(0, 1);
                far_gap   = close_gap;
                // first strict minimum and maximum in row order
                for (int unsigned i = 0; i + 1 < loaded_count; i++) begin
                    for (int unsigned j = i + 1; j < loaded_count; j++) begin
                        g = gap_between(i, j);
                        if (g < close_gap) begin
                            close_gap = g;
                            c1 = i;
                            c2 = j;
                        end
                        if (g > far_gap) begin
                            far_gap = g;
                            f1 = i;
                            f2 = j;
                        end
                    end
                end
                reports_due.push_back(date_report(ROLE_CLOSE_A, c1, close_gap, 1'b0));
                reports_due.push_back(date_report(ROLE_CLOSE_B, c2, close_gap, 1'b0));
                reports_due.push_back(date_report(ROLE_FAR_A, f1, far_gap, 1'b0));
                reports_due.push_back(date_report(ROLE_FAR_B, f2, far_gap, 1'b1));
            end
            loaded_count   = 0;
            set_overflowed = 1'b0;
        end
    endtask

    // watch both channels at every edge
    always @(posedge aclk) begin
        pair_report_t seen;
        pair_report_t want;
        if (!aresetn) begin
            loaded_count   = 0;
            set_overflowed = 1'b0;
            fault_total    = 0;
            reports_due.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                load_and_search(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                seen.pad     = m_axis_tdata[55:53];
                seen.dropped = m_axis_tdata[52];
                seen.gap     = m_axis_tdata[51:30];
                seen.year    = m_axis_tdata[29:16];
                seen.month   = m_axis_tdata[15:12];
                seen.day     = m_axis_tdata[11:7];
                seen.index   = m_axis_tdata[6:0];
                seen.too_few = m_axis_tuser[2];
                seen.role    = m_axis_tuser[1:0];
                seen.last    = m_axis_tlast;
                if (reports_due.size() == 0) begin
                    fault_total++;
                    if (fault_total <= 10)
                        $display("%0t unexpected result: %s", $realtime, describe(seen));
                end else begin
                    want = reports_due.pop_front();
                    if (seen !== want) begin
                        fault_total++;
                        if (fault_total <= 10)
                            $display("%0t result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe(want), describe(seen));
                    end
                end
            end
        end
        fail_count <= fault_total;
        pending    <= reports_due.size();
    end

endmodule

### tb/tb_closest_farthest_date_pair.sv
// testbench top for the date pair search block: stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps

module tb_closest_farthest_date_pair;
    import cfdp_pkg::*;

    localparam int SET_DEPTH    = 128;
    localparam int RANDOM_DATES = 350;
    localparam int CALM_AFTER   = 300;
    localparam int STALL_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 50;

    // date as it sits in the input transaction, day in the lowest bits
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } cal_date_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int unsigned fail_count;
    int unsigned pending;
    logic        calm_tail   = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned quiet_edges = 0;
    cal_date_t   recent_date = '0;

    always #5 aclk = ~aclk;

    closest_farthest_date_pair #(
        .MAX_DATES (SET_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cfdp_pair_checker #(
        .DEPTH (SET_DEPTH)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // result side stalls in bursts of random length
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_edges <= 0;
        else
            quiet_edges <= quiet_edges + 1;
        if (quiet_edges >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic cal_date_t mk_date(input int unsigned y, input int unsigned m,
                                          input int unsigned d);
        cal_date_t r;
        r.year  = y[YEAR_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.day   = d[DAY_W-1:0];
        return r;
    endfunction

    // mostly plausible dates, some close to the previous one, some with any field value
    function automatic cal_date_t random_date(input cal_date_t prev);
        int unsigned pick;
        cal_date_t   r;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            r = mk_date($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 28));
        end else if (pick <= 7) begin
            r     = prev;
            r.day = $urandom_range(1, 31);
        end else if (pick == 8) begin
            r = prev;
        end else begin
            r = mk_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
        end
        return r;
    endfunction

    // one input transaction, at times with a random idle burst ahead of it
    task automatic send_date(input cal_date_t dt, input logic fin);
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, dt};
        s_axis_tlast  <= fin;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        recent_date = dt;
    endtask

    initial begin
        int unsigned sent;
        int unsigned set_size;
        bit          big_done;
        sent     = 0;
        big_done = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single date: too few
        send_date(mk_date(2000, 2, 29), 1'b1);
        // widest legal span
        send_date(mk_date(1, 1, 1), 1'b0);
        send_date(mk_date(9999, 12, 31), 1'b1);
        // year zero, month zero, saturated serial, month above twelve, day past month end
        send_date(mk_date(0, 0, 0), 1'b0);
        send_date(mk_date(16383, 15, 31), 1'b0);
        send_date(mk_date(2021, 13, 31), 1'b0);
        send_date(mk_date(2021, 2, 31), 1'b1);
        // ties: first pair must win
        send_date(mk_date(2024, 6, 15), 1'b0);
        send_date(mk_date(2024, 6, 15), 1'b0);
        send_date(mk_date(1990, 1, 1), 1'b0);
        send_date(mk_date(2024, 6, 15), 1'b0);
        send_date(mk_date(2030, 12, 31), 1'b1);
        // century and quad-century leap rules
        send_date(mk_date(1900, 3, 1), 1'b0);
        send_date(mk_date(2000, 3, 1), 1'b0);
        send_date(mk_date(2004, 3, 1), 1'b0);
        send_date(mk_date(2100, 2, 28), 1'b0);
        send_date(mk_date(2100, 3, 1), 1'b1);
        // descending pair
        send_date(mk_date(2020, 5, 5), 1'b0);
        send_date(mk_date(1999, 1, 1), 1'b1);
        // too few right after a full set, day zero
        send_date(mk_date(1, 1, 0), 1'b1);

        // random sets, mostly small, one past capacity
        while (sent < RANDOM_DATES) begin
            if (!big_done && sent >= 150) begin
                set_size = SET_DEPTH + $urandom_range(1, 3);
                big_done = 1;
            end else if ($urandom_range(0, 11) == 0) begin
                set_size = 1;
            end else begin
                set_size = $urandom_range(2, 10);
            end
            for (int unsigned k = 0; k < set_size; k++)
                send_date(random_date(recent_date), k == set_size - 1);
            sent += set_size;
            if (sent >= CALM_AFTER)
                calm_tail <= 1'b1;
        end
        s_axis_tvalid <= 1'b0;

        // drain the remaining reports
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/cfdp_pkg.sv
rtl/cfdp_front.sv
rtl/cfdp_queue.sv
rtl/cfdp_back.sv
rtl/closest_farthest_date_pair.sv
tb/cfdp_pair_checker.sv
tb/tb_closest_farthest_date_pair.sv
